>>> hw/rtl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants of the keypad code lock: key codes, event
// codes, menu modes, register map and configuration defaults.
// ----------------------------------------------------------------------------
package kcl_pkg;

	// key codes
	localparam logic [3:0] KEY_DIGIT_LAST = 4'd9;
	localparam logic [3:0] KEY_CLEAR      = 4'd10;
	localparam logic [3:0] KEY_BACK       = 4'd11;
	localparam logic [3:0] KEY_ENTER      = 4'd12;
	localparam logic [3:0] KEY_CANCEL     = 4'd13;

	// result event codes
	typedef enum logic [2:0] {
		EVT_NONE   = 3'd0,
		EVT_EDIT   = 3'd1,
		EVT_OK     = 3'd2,
		EVT_FAIL   = 3'd3,
		EVT_CANCEL = 3'd4
	} evt_t;

	// menu modes
	typedef enum logic [1:0] {
		MODE_MAIN  = 2'd0,
		MODE_ENTRY = 2'd1,
		MODE_TIP   = 2'd2
	} mode_t;

	// register map, index = paddr[3:2]
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;
	localparam logic [1:0] REG_CODE_DIGITS = 2'd0;
	localparam logic [1:0] REG_CODE_LENGTH = 2'd1;
	localparam logic [1:0] REG_DEBOUNCE    = 2'd2;

	// stored code has six 4-bit digits
	localparam int unsigned CODE_DIGITS_N = 6;
	localparam logic [2:0]  CODE_LEN_MAX  = 3'd6;

	typedef struct packed {
		logic [23:0] code_digits;
		logic [2:0]  code_length;
		logic [15:0] debounce_ms;
	} cfg_t;

	localparam logic [23:0] CODE_DIGITS_RST = 24'h123456;
	localparam logic [2:0]  CODE_LENGTH_RST = 3'd6;
	localparam logic [15:0] DEBOUNCE_RST    = 16'd300;

endpackage

>>> hw/rtl/kcl_regs.sv
// ----------------------------------------------------------------------------
// kcl_regs
// APB-style configuration registers: stored code, code length and debounce
// interval, with read-back.
// ----------------------------------------------------------------------------
module kcl_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kcl_pkg::ADDR_W-1:0]    paddr,
	input  logic [kcl_pkg::DATA_W-1:0]    pwdata,
	output logic [kcl_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output kcl_pkg::cfg_t                 cfg
);
	import kcl_pkg::*;

	logic       wr_en;
	logic [1:0] reg_idx;
	cfg_t       cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code_digits <= CODE_DIGITS_RST;
			cfg_q.code_length <= CODE_LENGTH_RST;
			cfg_q.debounce_ms <= DEBOUNCE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CODE_DIGITS: cfg_q.code_digits <= pwdata[23:0];
				REG_CODE_LENGTH: cfg_q.code_length <= pwdata[2:0];
				REG_DEBOUNCE:    cfg_q.debounce_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_CODE_DIGITS: prdata = DATA_W'(cfg_q.code_digits);
			REG_CODE_LENGTH: prdata = DATA_W'(cfg_q.code_length);
			REG_DEBOUNCE:    prdata = DATA_W'(cfg_q.debounce_ms);
			default:         prdata = '0;
		endcase
	end

endmodule

>>> hw/rtl/kcl_core.sv
// ----------------------------------------------------------------------------
// kcl_core
// Lock state and combinational key handling: debounce check, entry editing,
// parallel code compare and mode update.
// ----------------------------------------------------------------------------
module kcl_core #(
	parameter int unsigned MAX_ENTRY      = 16,
	parameter int unsigned COMPARE_DIGITS = 6,
	parameter int unsigned CNT_W          = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kcl_pkg::cfg_t        cfg,
	input  logic                 step,
	input  logic [3:0]           key_code,
	input  logic [31:0]          time_ms,
	output logic                 key_taken,
	output kcl_pkg::evt_t        evt,
	output kcl_pkg::mode_t       mode,
	output logic [CNT_W-1:0]     count
);
	import kcl_pkg::*;

	localparam int unsigned CMP_N = (COMPARE_DIGITS < CODE_DIGITS_N) ?
		COMPARE_DIGITS : CODE_DIGITS_N;

	// lock state
	logic [31:0]      last_q;
	logic [3:0]       dig_q [COMPARE_DIGITS];
	logic [CNT_W-1:0] count_q;
	mode_t            mode_q;

	logic [31:0]      last_n;
	logic [3:0]       dig_n [COMPARE_DIGITS];
	logic [CNT_W-1:0] count_n;
	logic [CNT_W-1:0] count_dec;
	mode_t            mode_n;
	evt_t             evt_n;
	logic             taken;
	logic [31:0]      elapsed;
	logic [7:0]       cnt8;
	logic [7:0]       dec8;
	logic [7:0]       n8;
	logic [7:0]       m8;
	logic [2:0]       len_cl;
	logic             match;

	// debounce check on wrapping timestamp
	assign elapsed   = time_ms - last_q;
	assign taken     = elapsed >= 32'(cfg.debounce_ms);
	assign cnt8      = 8'(count_q);
	assign count_dec = count_q - CNT_W'(1);
	assign dec8      = 8'(count_dec);

	// strncmp-style compare over the first digits
	always_comb begin
		len_cl = (cfg.code_length > CODE_LEN_MAX) ? CODE_LEN_MAX : cfg.code_length;
		m8     = (8'(len_cl) > 8'(COMPARE_DIGITS)) ? 8'(COMPARE_DIGITS) : 8'(len_cl);
		n8     = (cnt8 > 8'(COMPARE_DIGITS)) ? 8'(COMPARE_DIGITS) : cnt8;
		match  = (n8 == m8);
		for (int i = 0; i < CMP_N; i++) begin
			if ((8'(i) < m8) &&
			    (dig_q[i] != cfg.code_digits[(CODE_DIGITS_N-1-i)*4 +: 4]))
				match = 1'b0;
		end
	end

	// next state and result
	always_comb begin
		last_n  = last_q;
		dig_n   = dig_q;
		count_n = count_q;
		mode_n  = mode_q;
		evt_n   = EVT_NONE;
		if (taken) begin
			last_n = time_ms;
			case (key_code) inside
				[4'd0:KEY_DIGIT_LAST]: begin
					if (count_q < CNT_W'(MAX_ENTRY)) begin
						for (int i = 0; i < COMPARE_DIGITS; i++) begin
							if (cnt8 == 8'(i))
								dig_n[i] = key_code;
						end
						count_n = count_q + CNT_W'(1);
					end
					mode_n = MODE_ENTRY;
					evt_n  = EVT_EDIT;
				end
				KEY_CLEAR: begin
					for (int i = 0; i < COMPARE_DIGITS; i++)
						dig_n[i] = 4'd0;
					count_n = '0;
					mode_n  = MODE_ENTRY;
					evt_n   = EVT_EDIT;
				end
				KEY_BACK: begin
					if (count_q != '0) begin
						for (int i = 0; i < COMPARE_DIGITS; i++) begin
							if (dec8 == 8'(i))
								dig_n[i] = 4'd0;
						end
						count_n = count_dec;
					end
					mode_n = MODE_ENTRY;
					evt_n  = EVT_EDIT;
				end
				KEY_ENTER: begin
					for (int i = 0; i < COMPARE_DIGITS; i++)
						dig_n[i] = 4'd0;
					count_n = '0;
					mode_n  = MODE_TIP;
					evt_n   = match ? EVT_OK : EVT_FAIL;
				end
				KEY_CANCEL: begin
					for (int i = 0; i < COMPARE_DIGITS; i++)
						dig_n[i] = 4'd0;
					count_n = '0;
					mode_n  = MODE_MAIN;
					evt_n   = EVT_CANCEL;
				end
				default: ;
			endcase
		end
	end

	assign key_taken = taken;
	assign evt       = evt_n;
	assign mode      = mode_n;
	assign count     = count_n;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			count_q <= '0;
			mode_q  <= MODE_MAIN;
			for (int i = 0; i < COMPARE_DIGITS; i++)
				dig_q[i] <= 4'd0;
		end else if (step) begin
			last_q  <= last_n;
			count_q <= count_n;
			mode_q  <= mode_n;
			dig_q   <= dig_n;
		end
	end

endmodule

>>> hw/rtl/keypad_code_lock.sv
// Pipeline: a key word accepted into the input register has its result word loaded
// into the result register when that register is free or being drained.
// Throughput: one key word per cycle unless the receiver stalls; the lock state is
// updated in the cycle that loads the result register, so the next word sees it.
// Reset: asynchronous; entry empty, main mode, last press time zero, config
// registers at code 123456, length 6, debounce 300 ms.
// ----------------------------------------------------------------------------
// keypad_code_lock
// Keypad code lock with debounce, digit entry, code check and APB-style
// configuration port.
// ----------------------------------------------------------------------------
module keypad_code_lock #(
	parameter int unsigned MAX_ENTRY      = 16,
	parameter int unsigned COMPARE_DIGITS = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// key words
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic [3:0]                         key_code,
	input  logic [31:0]                        time_ms,
	// result words
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic                               key_taken,
	output logic [2:0]                         event_code,
	output logic [1:0]                         menu_mode,
	output logic [$clog2(MAX_ENTRY+1)-1:0]     entered_count,
	// configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [kcl_pkg::ADDR_W-1:0]         paddr,
	input  logic [kcl_pkg::DATA_W-1:0]         pwdata,
	output logic [kcl_pkg::DATA_W-1:0]         prdata,
	output logic                               pready
);
	import kcl_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_ENTRY + 1);

	cfg_t             cfg;
	logic             advance;
	logic             valid_s1;
	logic [3:0]       key_s1;
	logic [31:0]      time_s1;
	logic             rsp_valid_q;
	logic             taken_c;
	evt_t             evt_c;
	mode_t            mode_c;
	logic [CNT_W-1:0] count_c;
	logic             taken_q;
	logic [2:0]       evt_q;
	logic [1:0]       mode_q;
	logic [CNT_W-1:0] count_q;

	// configuration registers
	kcl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// pipeline moves when the result register is free or being drained
	assign advance   = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req_ready)
			valid_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			key_s1  <= key_code;
			time_s1 <= time_ms;
		end
	end

	// key handling and lock state
	kcl_core #(
		.MAX_ENTRY      (MAX_ENTRY),
		.COMPARE_DIGITS (COMPARE_DIGITS),
		.CNT_W          (CNT_W)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (valid_s1 && advance),
		.key_code  (key_s1),
		.time_ms   (time_s1),
		.key_taken (taken_c),
		.evt       (evt_c),
		.mode      (mode_c),
		.count     (count_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (advance)
			rsp_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			taken_q <= taken_c;
			evt_q   <= evt_c;
			mode_q  <= mode_c;
			count_q <= count_c;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign key_taken     = taken_q;
	assign event_code    = evt_q;
	assign menu_mode     = mode_q;
	assign entered_count = count_q;

endmodule

>>> sim/keypad_code_lock_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_code_lock_check
// Watches the key, result and configuration ports of the keypad code lock.
// Keeps its own model of the lock, queues the expected result word of each
// accepted key word and compares every accepted result word field by field.
// ----------------------------------------------------------------------------
module keypad_code_lock_check #(
	parameter int unsigned MAX_ENTRY      = 16,
	parameter int unsigned COMPARE_DIGITS = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	input  logic                               req_ready,
	input  logic [3:0]                         key_code,
	input  logic [31:0]                        time_ms,
	input  logic                               rsp_valid,
	input  logic                               rsp_ready,
	input  logic                               key_taken,
	input  logic [2:0]                         event_code,
	input  logic [1:0]                         menu_mode,
	input  logic [$clog2(MAX_ENTRY+1)-1:0]     entered_count,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [kcl_pkg::ADDR_W-1:0]         paddr,
	input  logic [kcl_pkg::DATA_W-1:0]         pwdata,
	input  logic                               pready,
	output int                                 fails,
	output int                                 open_words
);

	localparam int unsigned CNT_W = $clog2(MAX_ENTRY + 1);

	typedef struct packed {
		logic             taken;
		kcl_pkg::evt_t    ev;
		kcl_pkg::mode_t   mode;
		logic [CNT_W-1:0] count;
	} lock_word_t;

	// configuration copy
	logic [23:0] code_q;
	logic [2:0]  len_q;
	logic [15:0] deb_q;

	// lock state copy
	logic [31:0]    last_ms;
	logic [3:0]     digits [COMPARE_DIGITS];
	int unsigned    count_q;
	kcl_pkg::mode_t mode_q;

	lock_word_t expected_words [$];

	function automatic void clear_entry();
		for (int i = 0; i < COMPARE_DIGITS; i++)
			digits[i] = 4'd0;
		count_q = 0;
	endfunction

	// prefix compare over at most six digits
	function automatic bit code_matches();
		int unsigned n;
		int unsigned m;
		n = (count_q > COMPARE_DIGITS) ? COMPARE_DIGITS : count_q;
		m = 32'((len_q > kcl_pkg::CODE_LEN_MAX) ? kcl_pkg::CODE_LEN_MAX : len_q);
		if (m > COMPARE_DIGITS)
			m = COMPARE_DIGITS;
		if (n != m)
			return 1'b0;
		for (int i = 0; i < m && i < kcl_pkg::CODE_DIGITS_N; i++)
			if (digits[i] != code_q[23 - 4*i -: 4])
				return 1'b0;
		return 1'b1;
	endfunction

	// advance the lock by one key word and return its result word
	function automatic lock_word_t press_outcome(input logic [3:0] key, input logic [31:0] stamp);
		lock_word_t w;
		logic [31:0] gap;
		w.taken = 1'b0;
		w.ev    = kcl_pkg::EVT_NONE;
		gap     = stamp - last_ms;
		if (gap >= {16'd0, deb_q}) begin
			w.taken = 1'b1;
			last_ms = stamp;
			if (key <= kcl_pkg::KEY_DIGIT_LAST) begin
				// a full entry drops the digit but still counts as an edit
				if (count_q < MAX_ENTRY) begin
					if (count_q < COMPARE_DIGITS)
						digits[count_q] = key;
					count_q++;
				end
				mode_q = kcl_pkg::MODE_ENTRY;
				w.ev   = kcl_pkg::EVT_EDIT;
			end else if (key == kcl_pkg::KEY_CLEAR) begin
				clear_entry();
				mode_q = kcl_pkg::MODE_ENTRY;
				w.ev   = kcl_pkg::EVT_EDIT;
			end else if (key == kcl_pkg::KEY_BACK) begin
				if (count_q > 0) begin
					count_q--;
					if (count_q < COMPARE_DIGITS)
						digits[count_q] = 4'd0;
				end
				mode_q = kcl_pkg::MODE_ENTRY;
				w.ev   = kcl_pkg::EVT_EDIT;
			end else if (key == kcl_pkg::KEY_ENTER) begin
				w.ev = code_matches() ? kcl_pkg::EVT_OK : kcl_pkg::EVT_FAIL;
				clear_entry();
				mode_q = kcl_pkg::MODE_TIP;
			end else if (key == kcl_pkg::KEY_CANCEL) begin
				clear_entry();
				mode_q = kcl_pkg::MODE_MAIN;
				w.ev   = kcl_pkg::EVT_CANCEL;
			end
		end
		w.mode  = mode_q;
		w.count = count_q[CNT_W-1:0];
		return w;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			fails++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		lock_word_t want;
		if (!arst_n) begin
			code_q  = kcl_pkg::CODE_DIGITS_RST;
			len_q   = kcl_pkg::CODE_LENGTH_RST;
			deb_q   = kcl_pkg::DEBOUNCE_RST;
			last_ms = 32'd0;
			clear_entry();
			mode_q  = kcl_pkg::MODE_MAIN;
			expected_words.delete();
			open_words <= 0;
		end else begin
			// result word out
			if (rsp_valid && rsp_ready) begin
				if (expected_words.size() == 0) begin
					fails++;
					$display("%0t: result word with none expected: taken %0d event %0d mode %0d count %0d",
						$time, key_taken, event_code, menu_mode, entered_count);
				end else begin
					want = expected_words.pop_front();
					check_field("key_taken", 8'(want.taken), 8'(key_taken));
					check_field("event_code", 8'(want.ev), 8'(event_code));
					check_field("menu_mode", 8'(want.mode), 8'(menu_mode));
					check_field("entered_count", 8'(want.count), 8'(entered_count));
				end
			end
			// register write
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					kcl_pkg::REG_CODE_DIGITS: code_q = pwdata[23:0];
					kcl_pkg::REG_CODE_LENGTH: len_q = pwdata[2:0];
					kcl_pkg::REG_DEBOUNCE: deb_q = pwdata[15:0];
					default: ;
				endcase
			end
			// key word in
			if (req_valid && req_ready)
				expected_words.push_back(press_outcome(key_code, time_ms));
			open_words <= expected_words.size();
		end
	end

endmodule

>>> sim/keypad_code_lock_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_code_lock_tb
// Drives key words and register writes into the keypad code lock: a short
// directed run, then code-entry sequences with random content over several
// register settings and idle patterns. The checker beside the block judges
// every result word; this module reports the verdict.
// ----------------------------------------------------------------------------
module keypad_code_lock_tb;
	import kcl_pkg::*;

	localparam int unsigned MAX_ENTRY      = 16;
	localparam int unsigned COMPARE_DIGITS = 6;
	localparam int unsigned CNT_W          = $clog2(MAX_ENTRY + 1);
	localparam int unsigned HALF_PERIOD    = 5;
	localparam int unsigned PHASES         = 8;
	localparam int unsigned PRESS_TARGET   = 1400;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned CYCLE_LIMIT    = 300000;

	// keys that carry no action
	localparam logic [3:0] KEY_NONE_A = 4'd14;
	localparam logic [3:0] KEY_NONE_B = 4'd15;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      req_valid = 1'b0;
	logic                      req_ready;
	logic [3:0]                key_code = 4'd0;
	logic [31:0]               time_ms = 32'd0;
	logic                      rsp_valid;
	logic                      rsp_ready = 1'b0;
	logic                      key_taken;
	logic [2:0]                event_code;
	logic [1:0]                menu_mode;
	logic [CNT_W-1:0]          entered_count;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [ADDR_W-1:0]         paddr = '0;
	logic [DATA_W-1:0]         pwdata = '0;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;
	int                        fails;
	int                        open_words;

	// stimulus-side view of the lock settings and timing
	logic [23:0]  cur_code = CODE_DIGITS_RST;
	logic [2:0]   cur_len = CODE_LENGTH_RST;
	logic [15:0]  cur_deb = DEBOUNCE_RST;
	logic [31:0]  last_take = 32'd0;
	int unsigned  presses_taken = 0;
	int unsigned  hold_pct = 0;
	int unsigned  stall_pct = 0;
	int unsigned  cycle_count = 0;

	keypad_code_lock #(
		.MAX_ENTRY(MAX_ENTRY),
		.COMPARE_DIGITS(COMPARE_DIGITS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.key_code(key_code), .time_ms(time_ms),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.key_taken(key_taken), .event_code(event_code),
		.menu_mode(menu_mode), .entered_count(entered_count),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	keypad_code_lock_check #(
		.MAX_ENTRY(MAX_ENTRY),
		.COMPARE_DIGITS(COMPARE_DIGITS)
	) result_check (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.key_code(key_code), .time_ms(time_ms),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.key_taken(key_taken), .event_code(event_code),
		.menu_mode(menu_mode), .entered_count(entered_count),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fails(fails), .open_words(open_words)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// one key word, with a random idle gap in front
	task automatic send_key(input logic [3:0] key, input logic [31:0] stamp);
		int unsigned gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < hold_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		key_code  <= key;
		time_ms   <= stamp;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (stamp - last_take >= {16'd0, cur_deb}) begin
			last_take = stamp;
			presses_taken++;
		end
	endtask

	// stop sending and wait for every outstanding result word
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (open_words != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [3:0] code_digit(input int unsigned i);
		return cur_code[23 - 4*i -: 4];
	endfunction

	function automatic logic [23:0] decimal_code();
		logic [23:0] c;
		c = '0;
		repeat (CODE_DIGITS_N) c = {c[19:0], 4'($urandom_range(9))};
		return c;
	endfunction

	// mostly spaced presses, a few bounces and jumps anywhere in time
	function automatic logic [31:0] next_stamp();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 3)
			return $urandom();
		if (r < 9 && cur_deb != 0)
			return last_take + $urandom_range(cur_deb - 1);
		return last_take + cur_deb + $urandom_range(r < 60 ? 3 : 2000);
	endfunction

	task automatic load_setting(input int unsigned phase);
		logic [23:0] code;
		logic [2:0]  len;
		logic [15:0] deb;
		code = decimal_code();
		case (phase)
			0: begin code = CODE_DIGITS_RST; len = CODE_LENGTH_RST; deb = DEBOUNCE_RST; end
			1: begin len = 3'd6; deb = 16'd0; end
			2: begin code = 24'h000000; len = 3'd0; deb = 16'd1; end
			3: begin code = 24'hFFFFFF; len = 3'd6; deb = 16'hFFFF; end
			4: begin len = 3'd7; deb = 16'd20; end
			5: begin len = 3'($urandom_range(1, 5)); deb = 16'($urandom_range(1, 500)); end
			6: begin len = 3'd3; deb = 16'hFFFF; end
			default: begin
				code = 24'($urandom());
				len  = 3'($urandom_range(7));
				deb  = 16'($urandom());
			end
		endcase
		write_reg(REG_CODE_DIGITS, {8'd0, code});
		write_reg(REG_CODE_LENGTH, {29'd0, len});
		write_reg(REG_DEBOUNCE, {16'd0, deb});
		cur_code = code;
		cur_len  = len;
		cur_deb  = deb;
	endtask

	// one code-entry attempt, well formed most of the time
	task automatic run_sequence();
		logic [3:0]  keys [$];
		logic [3:0]  digit;
		int unsigned kind;
		int unsigned code_n;
		int unsigned pos;
		int unsigned extra;
		code_n = 32'((cur_len > CODE_LEN_MAX) ? CODE_LEN_MAX : cur_len);
		kind = $urandom_range(9);
		if ($urandom_range(3) != 0)
			keys.push_back($urandom_range(1) ? KEY_CLEAR : KEY_CANCEL);
		case (kind)
			// right code
			0, 1, 2: begin
				for (int i = 0; i < code_n; i++)
					keys.push_back(code_digit(i));
				keys.push_back(KEY_ENTER);
			end
			// one digit wrong
			3, 4: begin
				pos = $urandom_range(code_n > 0 ? code_n - 1 : 0);
				for (int i = 0; i < code_n; i++) begin
					digit = code_digit(i);
					if (i == pos)
						digit = 4'((digit + 1 + $urandom_range(8)) % 10);
					keys.push_back(digit);
				end
				keys.push_back(KEY_ENTER);
			end
			// one digit short, or trailing digits past the code
			5: begin
				extra = $urandom_range(1) ? $urandom_range(1, 12) : 0;
				for (int i = 0; i < code_n; i++)
					if (extra != 0 || i + 1 < code_n)
						keys.push_back(code_digit(i));
				repeat (extra) keys.push_back(4'($urandom_range(9)));
				keys.push_back(KEY_ENTER);
			end
			// typo fixed with backspace
			6: begin
				pos = $urandom_range(code_n);
				for (int i = 0; i <= code_n; i++) begin
					if (i == pos) begin
						keys.push_back(4'($urandom_range(9)));
						keys.push_back(KEY_BACK);
					end
					if (i < code_n)
						keys.push_back(code_digit(i));
				end
				keys.push_back(KEY_ENTER);
			end
			// long entry, up to past full
			7: begin
				repeat ($urandom_range(7, 20)) begin
					keys.push_back(4'($urandom_range(9)));
					if ($urandom_range(6) == 0)
						keys.push_back(KEY_BACK);
				end
				keys.push_back($urandom_range(3) == 0 ? KEY_CANCEL : KEY_ENTER);
			end
			// backspace on an empty entry first
			8: begin
				keys.push_back(KEY_CLEAR);
				repeat ($urandom_range(1, 3)) keys.push_back(KEY_BACK);
				for (int i = 0; i < code_n; i++)
					keys.push_back(code_digit(i));
				keys.push_back(KEY_ENTER);
			end
			// noise
			default: repeat ($urandom_range(1, 8)) keys.push_back(4'($urandom_range(15)));
		endcase
		foreach (keys[i])
			send_key(keys[i], next_stamp());
	endtask

	initial begin : stimulus
		int unsigned phase_goal;
		bit          paused;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: debounce edges, a good and a bad code, every non-digit key, time wrap
		send_key(4'd1, 32'd100);
		send_key(4'd1, 32'd300);
		send_key(4'd2, 32'd301);
		send_key(4'd2, 32'd600);
		send_key(4'd3, 32'd900);
		send_key(4'd4, 32'd1200);
		send_key(4'd5, 32'd1500);
		send_key(4'd6, 32'd1800);
		send_key(KEY_ENTER, 32'd2100);
		send_key(KEY_BACK, 32'd2400);
		send_key(4'd0, 32'd2700);
		send_key(4'd9, 32'd3000);
		send_key(KEY_BACK, 32'd3300);
		send_key(KEY_CLEAR, 32'd3600);
		send_key(KEY_NONE_B, 32'd3900);
		send_key(KEY_NONE_A, 32'd4200);
		send_key(4'd9, 32'd4500);
		send_key(KEY_ENTER, 32'd4800);
		send_key(KEY_CANCEL, 32'd5100);
		send_key(4'd5, 32'hFFFF_FF00);
		send_key(4'd7, 32'h0000_002C);
		send_key(KEY_ENTER, 32'h0000_0158);

		// random: one register setting and one idle pattern per phase
		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			load_setting(phase);
			case (phase % 4)
				0: begin hold_pct = 0;  stall_pct <= 0;  end
				1: begin hold_pct = 54; stall_pct <= 0;  end
				2: begin hold_pct = 0;  stall_pct <= 54; end
				default: begin hold_pct = 23; stall_pct <= 23; end
			endcase
			phase_goal = presses_taken + PRESS_TARGET / PHASES;
			paused = 1'b0;
			while (presses_taken < phase_goal) begin
				run_sequence();
				// let the lock run dry once mid-phase
				if (!paused && presses_taken >= phase_goal - PRESS_TARGET / (2 * PHASES)) begin
					wait_drained();
					paused = 1'b1;
				end
			end
		end

		wait_drained();
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> keypad_code_lock.f
hw/rtl/kcl_pkg.sv
hw/rtl/kcl_regs.sv
hw/rtl/kcl_core.sv
hw/rtl/keypad_code_lock.sv
sim/keypad_code_lock_check.sv
sim/keypad_code_lock_tb.sv
